// File: hw/rtl/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the byte coded CPU step core
// Opcodes, request and register codes, reset values and decode helpers.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int MEM_BYTES_DEF = 65536;
   localparam int REG_COUNT     = 8;
   localparam int CFG_W         = 17;
   localparam int WORD_W        = 32;

   localparam logic [CFG_W-1:0] ROM_START_RST   = 17'd61440;
   localparam logic [CFG_W-1:0] ROM_END_RST     = 17'd65536;
   localparam logic [CFG_W-1:0] VIDEO_START_RST = 17'd32768;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_EXEC = 2'd2;

   localparam logic [1:0] CSR_ROM_START   = 2'd0;
   localparam logic [1:0] CSR_ROM_END     = 2'd1;
   localparam logic [1:0] CSR_VIDEO_START = 2'd2;

   localparam logic [7:0] OP_MOV8_IMM  = 8'h01;
   localparam logic [7:0] OP_MOV32_IMM = 8'h02;
   localparam logic [7:0] OP_ST8_ABS   = 8'h03;
   localparam logic [7:0] OP_ST32_ABS  = 8'h04;
   localparam logic [7:0] OP_LD8_ABS   = 8'h05;
   localparam logic [7:0] OP_LD32_ABS  = 8'h06;
   localparam logic [7:0] OP_MOV8      = 8'h07;
   localparam logic [7:0] OP_MOV32     = 8'h08;
   localparam logic [7:0] OP_ST8_IND   = 8'h09;
   localparam logic [7:0] OP_LD8_IND   = 8'h0A;
   localparam logic [7:0] OP_ADD8      = 8'h0B;
   localparam logic [7:0] OP_SUB8      = 8'h0C;
   localparam logic [7:0] OP_DIV8      = 8'h0D;
   localparam logic [7:0] OP_MUL8      = 8'h0E;
   localparam logic [7:0] OP_ADD32     = 8'h0F;
   localparam logic [7:0] OP_SUB32     = 8'h10;
   localparam logic [7:0] OP_DIV32     = 8'h11;
   localparam logic [7:0] OP_MUL32     = 8'h12;
   localparam logic [7:0] OP_JMP       = 8'h13;
   localparam logic [7:0] OP_JEQ       = 8'h14;
   localparam logic [7:0] OP_JNE       = 8'h15;
   localparam logic [7:0] OP_JLT       = 8'h16;
   localparam logic [7:0] OP_JGT       = 8'h17;
   localparam logic [7:0] OP_JLE       = 8'h18;
   localparam logic [7:0] OP_JGE       = 8'h19;
   localparam logic [7:0] OP_AND8      = 8'h1A;
   localparam logic [7:0] OP_OR8       = 8'h1B;
   localparam logic [7:0] OP_NOT8      = 8'h1C;
   localparam logic [7:0] OP_XOR8      = 8'h1D;
   localparam logic [7:0] OP_CMP8      = 8'h1E;
   localparam logic [7:0] OP_AND32     = 8'h1F;
   localparam logic [7:0] OP_OR32      = 8'h20;
   localparam logic [7:0] OP_NOT32     = 8'h21;
   localparam logic [7:0] OP_XOR32     = 8'h22;
   localparam logic [7:0] OP_CMP32     = 8'h23;
   localparam logic [7:0] OP_INC8      = 8'h24;
   localparam logic [7:0] OP_DEC8      = 8'h25;
   localparam logic [7:0] OP_SHL8      = 8'h26;
   localparam logic [7:0] OP_SHR8      = 8'h27;
   localparam logic [7:0] OP_INC32     = 8'h28;
   localparam logic [7:0] OP_DEC32     = 8'h29;
   localparam logic [7:0] OP_SHL32     = 8'h2A;
   localparam logic [7:0] OP_SHR32     = 8'h2B;
   localparam logic [7:0] OP_HLT       = 8'h2C;
   localparam logic [7:0] OP_STB_IMM   = 8'h2D;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_RD_DONE,
      ST_PC_VIDEO,
      ST_PC_RANGE,
      ST_FETCH_DONE,
      ST_MEM_ISSUE,
      ST_MEM_CAPTURE,
      ST_REG_A,
      ST_REG_B,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_WB,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic eq;
      logic ne;
      logic gt;
      logic lt;
      logic ge;
      logic le;
   } flags_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   // Operands of these opcodes come from the 32-bit bank.
   function automatic logic op_word_bank(input logic [7:0] op);
      case (op) inside
         OP_ST32_ABS, OP_MOV32, OP_ST8_IND, OP_LD8_IND, OP_ADD32, OP_SUB32, OP_DIV32,
         OP_MUL32, OP_AND32, OP_OR32, OP_NOT32, OP_XOR32, OP_CMP32, OP_INC32, OP_DEC32,
         OP_SHL32, OP_SHR32: op_word_bank = 1'b1;
         default: op_word_bank = 1'b0;
      endcase
   endfunction

   function automatic logic op_writes_byte(input logic [7:0] op);
      case (op) inside
         OP_MOV8_IMM, OP_LD8_ABS, OP_MOV8, OP_LD8_IND, OP_ADD8, OP_SUB8, OP_DIV8, OP_MUL8,
         OP_AND8, OP_OR8, OP_NOT8, OP_XOR8, OP_INC8, OP_DEC8, OP_SHL8, OP_SHR8:
            op_writes_byte = 1'b1;
         default: op_writes_byte = 1'b0;
      endcase
   endfunction

   function automatic logic op_writes_word(input logic [7:0] op);
      case (op) inside
         OP_MOV32_IMM, OP_LD32_ABS, OP_MOV32, OP_ADD32, OP_SUB32, OP_DIV32, OP_MUL32,
         OP_AND32, OP_OR32, OP_NOT32, OP_XOR32, OP_INC32, OP_DEC32, OP_SHL32, OP_SHR32:
            op_writes_word = 1'b1;
         default: op_writes_word = 1'b0;
      endcase
   endfunction

   function automatic logic op_long(input logic [7:0] op);
      case (op) inside
         OP_MOV32_IMM, OP_ST8_ABS, OP_ST32_ABS, OP_LD8_ABS, OP_LD32_ABS, OP_STB_IMM:
            op_long = 1'b1;
         default: op_long = 1'b0;
      endcase
   endfunction

endpackage

// File: hw/rtl/bcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_if: channel interfaces of the byte coded CPU step core
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bcc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] address;
   logic [7:0]  data;
   modport source (output valid, req_type, address, data, input ready);
   modport sink (input valid, req_type, address, data, output ready);
endinterface

interface bcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pc;
   logic        halted;
   logic        flag_equal;
   logic        flag_not_equal;
   logic        flag_greater;
   logic        flag_less;
   logic        flag_greater_eq;
   logic        flag_less_eq;
   logic [7:0]  read_data;
   modport source (output valid, pc, halted, flag_equal, flag_not_equal, flag_greater,
                   flag_less, flag_greater_eq, flag_less_eq, read_data, input ready);
   modport sink (input valid, pc, halted, flag_equal, flag_not_equal, flag_greater,
                 flag_less, flag_greater_eq, flag_less_eq, read_data, output ready);
endinterface

interface bcc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [16:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/bcc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_mem: single port byte memory
// One access per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bcc_mem #(
   parameter int MEM_BYTES = bcc_pkg::MEM_BYTES_DEF,
   parameter int AW        = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);
   logic [7:0] mem_ff [MEM_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/bcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bcc_pkg::div_req_type req,
   output logic                 done,
   output logic [31:0]          quotient
);
   import bcc_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] dvs_ff;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd31;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hw/rtl/byte_coded_cpu_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_coded_cpu_step: byte coded CPU core, one request per beat
// Loads and reads memory bytes or runs one instruction per request.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  req_ch  | in  | req_type, address, data
//  rsp_ch  | out | pc, halted, six compare flags, read_data
//  csr_ch  | in  | index, wdata (rom_start, rom_end, video_start)
//
// A load writes its byte and a read fetches its byte before the response is given.
// An instruction runs the PC checks, the six byte fetch on the single memory
// port, a latch of the fetched bytes, the two register reads, execute, write back
// and the response. Loads and stores add their byte accesses and a divide by a
// nonzero divisor its divider wait. After reset the memory is cleared byte by byte
// before req_ch.ready rises. A stalled response holds the core until it is out.
module byte_coded_cpu_step #(
   parameter int MEM_BYTES = bcc_pkg::MEM_BYTES_DEF
) (
   input logic      clock,
   input logic      reset,
   bcc_req_if.sink  req_ch,
   bcc_rsp_if.source rsp_ch,
   bcc_csr_if.sink  csr_ch
);
   import bcc_pkg::*;

   localparam int          AW      = $clog2(MEM_BYTES);
   localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] rom_start_ff, rom_end_ff, video_start_ff;
   logic [31:0]      pc_ff;
   logic             halted_ff;
   flags_type        flags_ff;
   logic [7:0]       breg_ff [REG_COUNT];
   logic [31:0]      wreg_ff [REG_COUNT];

   logic [AW-1:0] clr_ff;
   logic [1:0]    rq_type_ff;
   logic [15:0]   rq_addr_ff;
   logic [7:0]    rq_data_ff;
   logic [7:0]    read_data_ff;
   logic [47:0]   instr_ff;
   logic [31:0]   opa_ff, opb_ff, res_ff;

   // Byte access sequencer shared by fetch, loads, stores and read requests.
   logic [31:0] ma_base_ff;
   logic [2:0]  mk_ff, mlast_ff;
   logic        mwr_ff, mw_ok_ff, rd_ok_ff, rbase_ok_ff;
   logic [31:0] mwdata_ff;
   logic [47:0] acc_ff;
   state_type   mret_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_pc_ff;
   logic        rsp_halted_ff;
   flags_type   rsp_flags_ff;
   logic [7:0]  rsp_rd_ff;

   logic [7:0]  op, b1, b2, b3, b5;
   logic [31:0] hi, lo;
   logic        req_fire, rsp_load, word_bank, mem_last;
   logic [31:0] ma_addr, pc_p1, pc_fix;
   logic [7:0]  idx_a, idx_b, idx_sel;
   logic [31:0] reg_val;
   logic        exec_mem, exec_div, take;
   logic [31:0] cmp_x, cmp_y, res_in;
   logic        cmp_eq, cmp_gt;
   logic [7:0]  a8, b8;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_q;
   div_req_type   div_req;
   logic          div_done;
   logic [31:0]   div_q;

   function automatic logic [7:0] res_res8(input logic [7:0] code, input logic [31:0] r,
                                           input logic [47:0] acc);
      if (code == OP_LD8_ABS || code == OP_LD8_IND) begin
         res_res8 = acc[7:0];
      end else begin
         res_res8 = r[7:0];
      end
   endfunction

   assign op = instr_ff[47:40];
   assign b1 = instr_ff[39:32];
   assign b2 = instr_ff[31:24];
   assign b3 = instr_ff[23:16];
   assign b5 = instr_ff[7:0];
   assign hi = instr_ff[39:8];
   assign lo = instr_ff[31:0];
   assign a8 = opa_ff[7:0];
   assign b8 = opb_ff[7:0];

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ch.ready);
   assign word_bank = op_word_bank(op);
   assign ma_addr   = ma_base_ff + 32'(mk_ff);
   assign mem_last  = (mk_ff == mlast_ff);
   assign pc_p1     = pc_ff + 32'd1;
   assign pc_fix    = (pc_ff > 32'(rom_end_ff)) ? 32'd0 : pc_ff;

   // Operand register indexes; compares and the indirect store use b1 and b2.
   always_comb begin
      case (op) inside
         OP_ST8_IND, OP_CMP8, OP_CMP32: begin
            idx_a = b1;
            idx_b = b2;
         end
         OP_ST8_ABS, OP_ST32_ABS: begin
            idx_a = b5;
            idx_b = b3;
         end
         default: begin
            idx_a = b2;
            idx_b = b3;
         end
      endcase
      idx_sel = (state_ff == ST_REG_A) ? idx_a : idx_b;
      if (idx_sel[7:3] != 5'd0) begin
         reg_val = '0;
      end else if (word_bank) begin
         reg_val = wreg_ff[idx_sel[2:0]];
      end else begin
         reg_val = {24'd0, breg_ff[idx_sel[2:0]]};
      end
   end

   // Shared ALU of the execute state.
   always_comb begin
      cmp_x  = (op == OP_CMP8) ? {24'd0, a8} : opa_ff;
      cmp_y  = (op == OP_CMP8) ? {24'd0, b8} : opb_ff;
      cmp_eq = (cmp_x == cmp_y);
      cmp_gt = (cmp_x > cmp_y);
      case (op)
         OP_MOV8_IMM:  res_in = {24'd0, b2};
         OP_MOV32_IMM: res_in = lo;
         OP_MOV8:      res_in = opa_ff;
         OP_MOV32:     res_in = opa_ff;
         OP_ADD8:      res_in = {24'd0, a8 + b8};
         OP_SUB8:      res_in = {24'd0, a8 - b8};
         OP_MUL8:      res_in = {24'd0, 8'(a8 * b8)};
         OP_ADD32:     res_in = opa_ff + opb_ff;
         OP_SUB32:     res_in = opa_ff - opb_ff;
         OP_MUL32:     res_in = 32'(opa_ff * opb_ff);
         OP_AND8:      res_in = {24'd0, a8 & b8};
         OP_OR8:       res_in = {24'd0, a8 | b8};
         OP_NOT8:      res_in = {24'd0, ~a8};
         OP_XOR8:      res_in = {24'd0, a8 ^ b8};
         OP_AND32:     res_in = opa_ff & opb_ff;
         OP_OR32:      res_in = opa_ff | opb_ff;
         OP_NOT32:     res_in = ~opa_ff;
         OP_XOR32:     res_in = opa_ff ^ opb_ff;
         OP_INC8:      res_in = {24'd0, a8 + 8'd1};
         OP_DEC8:      res_in = {24'd0, a8 - 8'd1};
         OP_SHL8:      res_in = (b8 < 8'd8) ? {24'd0, a8 << b8[2:0]} : 32'd0;
         OP_SHR8:      res_in = (b8 < 8'd8) ? {24'd0, a8 >> b8[2:0]} : 32'd0;
         OP_INC32:     res_in = opa_ff + 32'd1;
         OP_DEC32:     res_in = opa_ff - 32'd1;
         OP_SHL32:     res_in = (opb_ff < 32'd32) ? opa_ff << opb_ff[4:0] : 32'd0;
         OP_SHR32:     res_in = (opb_ff < 32'd32) ? opa_ff >> opb_ff[4:0] : 32'd0;
         default:      res_in = 32'd0;
      endcase
      case (op) inside
         OP_ST8_ABS, OP_ST32_ABS, OP_LD8_ABS, OP_LD32_ABS, OP_ST8_IND, OP_LD8_IND,
         OP_STB_IMM: exec_mem = 1'b1;
         default: exec_mem = 1'b0;
      endcase
      exec_div = ((op == OP_DIV8) || (op == OP_DIV32)) && (opb_ff != 32'd0);
      case (op)
         OP_JMP:  take = 1'b1;
         OP_JEQ:  take = flags_ff.eq;
         OP_JNE:  take = flags_ff.ne;
         OP_JLT:  take = flags_ff.lt;
         OP_JGT:  take = flags_ff.gt;
         OP_JLE:  take = flags_ff.le;
         OP_JGE:  take = flags_ff.ge;
         default: take = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  REQ_LOAD: state_in = ST_LOAD;
                  REQ_READ: state_in = ST_MEM_ISSUE;
                  REQ_EXEC: state_in = halted_ff ? ST_RESP : ST_PC_VIDEO;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_LOAD:       state_in = ST_RESP;
         ST_RD_DONE:    state_in = ST_RESP;
         ST_PC_VIDEO:   state_in = ST_PC_RANGE;
         ST_PC_RANGE:   state_in = ST_MEM_ISSUE;
         ST_FETCH_DONE: state_in = ST_REG_A;
         ST_MEM_ISSUE: begin
            if (!mwr_ff) begin
               state_in = ST_MEM_CAPTURE;
            end else if (mem_last) begin
               state_in = mret_ff;
            end
         end
         ST_MEM_CAPTURE: state_in = mem_last ? mret_ff : ST_MEM_ISSUE;
         ST_REG_A:       state_in = ST_REG_B;
         ST_REG_B:       state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_mem) begin
               state_in = ST_MEM_ISSUE;
            end else if (exec_div) begin
               state_in = ST_DIV_WAIT;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory port, divider start, handshakes.
   always_comb begin
      mem_we       = 1'b0;
      mem_addr     = AW'(ma_addr);
      mem_wdata    = mwdata_ff[31:24];
      div_req      = '{start: 1'b0, dividend: opa_ff, divisor: opb_ff};
      req_ch.ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'd0;
         end
         ST_IDLE: req_ch.ready = 1'b1;
         ST_LOAD: begin
            mem_we    = {17'd0, rq_addr_ff} < MEM_LIM;
            mem_addr  = AW'(32'(rq_addr_ff));
            mem_wdata = rq_data_ff;
         end
         ST_MEM_ISSUE: mem_we = mwr_ff && mw_ok_ff && ({1'b0, ma_addr} < MEM_LIM);
         ST_EXEC: div_req.start = exec_div;
         default: ;
      endcase
   end

   assign csr_ch.ready = 1'b1;

   bcc_mem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_q)
   );

   bcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   // Control state and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         rom_start_ff   <= ROM_START_RST;
         rom_end_ff     <= ROM_END_RST;
         video_start_ff <= VIDEO_START_RST;
         pc_ff          <= 32'(ROM_START_RST);
         halted_ff      <= 1'b0;
         flags_ff       <= '0;
         for (int i = 0; i < REG_COUNT; i++) begin
            breg_ff[i] <= '0;
            wreg_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_ROM_START:   rom_start_ff   <= csr_ch.wdata;
               CSR_ROM_END:     rom_end_ff     <= csr_ch.wdata;
               CSR_VIDEO_START: video_start_ff <= csr_ch.wdata;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_PC_VIDEO: begin
               if ((pc_ff >= 32'(video_start_ff)) && (pc_p1 < 32'(rom_start_ff))) begin
                  pc_ff <= 32'd0;
               end
            end
            ST_PC_RANGE: pc_ff <= pc_fix;
            ST_EXEC: begin
               if (op == OP_CMP8 || op == OP_CMP32) begin
                  flags_ff.eq <= cmp_eq;
                  flags_ff.ne <= !cmp_eq;
                  flags_ff.gt <= cmp_gt;
                  // The 32-bit compare reports less as not greater.
                  flags_ff.lt <= (op == OP_CMP8) ? (!cmp_gt && !cmp_eq) : !cmp_gt;
                  flags_ff.ge <= cmp_gt || cmp_eq;
                  flags_ff.le <= !cmp_gt;
               end
            end
            ST_WB: begin
               if (op_writes_byte(op) && b1[7:3] == 5'd0) begin
                  breg_ff[b1[2:0]] <= res_res8(op, res_ff, acc_ff);
               end
               if (op_writes_word(op) && b1[7:3] == 5'd0) begin
                  wreg_ff[b1[2:0]] <= (op == OP_LD32_ABS) ? acc_ff[31:0] : res_ff;
               end
               if (op == OP_HLT) begin
                  halted_ff <= 1'b1;
               end else if (op >= OP_JMP && op <= OP_JGE) begin
                  pc_ff <= take ? hi : pc_ff + 32'd6;
               end else begin
                  pc_ff <= pc_ff + (op_long(op) ? 32'd6 : 32'd4);
               end
            end
            default: ;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rq_type_ff   <= req_ch.req_type;
               rq_addr_ff   <= req_ch.address;
               rq_data_ff   <= req_ch.data;
               read_data_ff <= 8'd0;
               ma_base_ff   <= {16'd0, req_ch.address};
               mk_ff        <= 3'd0;
               mlast_ff     <= 3'd0;
               mwr_ff       <= 1'b0;
               rbase_ok_ff  <= 1'b1;
               mret_ff      <= ST_RD_DONE;
            end
         end
         ST_RD_DONE: read_data_ff <= acc_ff[7:0];
         ST_PC_RANGE: begin
            ma_base_ff  <= pc_fix;
            mk_ff       <= 3'd0;
            mlast_ff    <= 3'd5;
            mwr_ff      <= 1'b0;
            rbase_ok_ff <= 1'b1;
            mret_ff     <= ST_FETCH_DONE;
         end
         ST_MEM_ISSUE: begin
            rd_ok_ff <= rbase_ok_ff && ({1'b0, ma_addr} < 33'(rom_end_ff)) &&
                        ({1'b0, ma_addr} < MEM_LIM);
            if (mwr_ff) begin
               mwdata_ff <= {mwdata_ff[23:0], 8'd0};
               mk_ff     <= mk_ff + 3'd1;
            end
         end
         ST_MEM_CAPTURE: begin
            acc_ff <= {acc_ff[39:0], rd_ok_ff ? mem_q : 8'd0};
            mk_ff  <= mk_ff + 3'd1;
         end
         ST_FETCH_DONE: instr_ff <= acc_ff;
         ST_REG_A:      opa_ff <= reg_val;
         ST_REG_B:      opb_ff <= reg_val;
         ST_EXEC: begin
            res_ff  <= res_in;
            mk_ff   <= 3'd0;
            mret_ff <= ST_WB;
            case (op)
               OP_ST8_ABS, OP_ST32_ABS, OP_STB_IMM: begin
                  ma_base_ff <= hi;
                  mwr_ff     <= 1'b1;
                  mw_ok_ff   <= (hi < 32'(rom_start_ff)) && (hi < 32'(rom_end_ff));
                  mlast_ff   <= (op == OP_ST32_ABS) ? 3'd3 : 3'd0;
                  mwdata_ff  <= (op == OP_STB_IMM) ? {b5, 24'd0} :
                                (op == OP_ST32_ABS) ? opa_ff : {opa_ff[7:0], 24'd0};
               end
               OP_ST8_IND: begin
                  ma_base_ff <= opa_ff;
                  mwr_ff     <= 1'b1;
                  mw_ok_ff   <= (opa_ff < 32'(rom_start_ff)) && (opa_ff < 32'(rom_end_ff));
                  mlast_ff   <= 3'd0;
                  mwdata_ff  <= {opb_ff[7:0], 24'd0};
               end
               OP_LD8_ABS, OP_LD32_ABS: begin
                  ma_base_ff  <= lo;
                  mwr_ff      <= 1'b0;
                  mlast_ff    <= (op == OP_LD32_ABS) ? 3'd3 : 3'd0;
                  // A word read past the end reads zero even if its later bytes wrap.
                  rbase_ok_ff <= (lo < 32'(rom_end_ff));
               end
               OP_LD8_IND: begin
                  ma_base_ff  <= opa_ff;
                  mwr_ff      <= 1'b0;
                  mlast_ff    <= 3'd0;
                  rbase_ok_ff <= 1'b1;
               end
               default: ;
            endcase
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_ff <= div_q;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_pc_ff     <= pc_ff;
               rsp_halted_ff <= halted_ff;
               rsp_flags_ff  <= flags_ff;
               rsp_rd_ff     <= (rq_type_ff == REQ_READ) ? read_data_ff : 8'd0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.pc              = rsp_pc_ff;
   assign rsp_ch.halted          = rsp_halted_ff;
   assign rsp_ch.flag_equal      = rsp_flags_ff.eq;
   assign rsp_ch.flag_not_equal  = rsp_flags_ff.ne;
   assign rsp_ch.flag_greater    = rsp_flags_ff.gt;
   assign rsp_ch.flag_less       = rsp_flags_ff.lt;
   assign rsp_ch.flag_greater_eq = rsp_flags_ff.ge;
   assign rsp_ch.flag_less_eq    = rsp_flags_ff.le;
   assign rsp_ch.read_data       = rsp_rd_ff;
endmodule

// File: hw/rtl/bcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_checker: port level checks of the byte coded CPU step core
// Watches the request and response beats over time.
// ----------------------------------------------------------------------------
module bcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pc,
   input logic        rsp_halted,
   input logic        rsp_eq,
   input logic        rsp_ne,
   input logic        rsp_gt,
   input logic        rsp_ge
);
   // A response beat that is stalled keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc) && $stable(rsp_halted))
      else $error("stalled response changed");

   // One request is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Once halted the core stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |=> !rsp_valid || rsp_halted)
      else $error("halt flag cleared");

   a_eq_ne: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_eq && rsp_ne))
      else $error("equal and not equal both set");

   a_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ge == (rsp_gt || rsp_eq))
      else $error("greater or equal flag inconsistent");
endmodule

bind byte_coded_cpu_step bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_pc     (rsp_ch.pc),
   .rsp_halted (rsp_ch.halted),
   .rsp_eq     (rsp_ch.flag_equal),
   .rsp_ne     (rsp_ch.flag_not_equal),
   .rsp_gt     (rsp_ch.flag_greater),
   .rsp_ge     (rsp_ch.flag_greater_eq)
);

// File: tb/byte_coded_cpu_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_coded_cpu_step_tb: self-checking bench of the byte coded CPU step core
// Loads small programs into memory, runs them one instruction per request and
// compares every response with a behavioral copy of the core kept in the bench.
// ----------------------------------------------------------------------------
module byte_coded_cpu_step_tb;
   import bcc_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } cpu_req_t;

   typedef struct packed {
      logic [31:0] pc;
      logic        halted;
      flags_type   flags;
      logic [7:0]  rdata;
   } cpu_rsp_t;

   localparam int MEMSZ = 65536;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [1:0] REQ_NOP = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcc_req_if req_ch ();
   bcc_rsp_if rsp_ch ();
   bcc_csr_if csr_ch ();

   byte_coded_cpu_step dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always #1 clock = ~clock;

   // Shadow state of the core.
   logic [7:0]  sh_mem [MEMSZ];
   logic [7:0]  sh_r8 [8];
   logic [31:0] sh_r32 [8];
   logic [31:0] sh_pc;
   flags_type   sh_flags;
   logic        sh_halt;
   logic [16:0] rom_start_q, rom_end_q, video_start_q;

   cpu_req_t pending_reqs[$];
   cpu_rsp_t expected_rsps[$];
   int       errors = 0;
   int       idle_cycles = 0;
   int       hold_off = 0;
   int       req_gap = 0;
   int       rsp_gap = 0;
   bit       source_pause = 1'b0;
   bit       req_taken = 1'b0;
   bit       rsp_taken = 1'b0;

   function automatic logic [7:0] rd8(logic [31:0] a);
      if (a >= rom_end_q || a >= MEMSZ) return 8'h00;
      return sh_mem[a[15:0]];
   endfunction

   function automatic logic [31:0] rd32(logic [31:0] a);
      if (a >= rom_end_q) return 32'h0;
      return {rd8(a), rd8(a + 1), rd8(a + 2), rd8(a + 3)};
   endfunction

   function automatic void wr8(logic [31:0] a, logic [7:0] v);
      if (a < rom_start_q && a < rom_end_q && a < MEMSZ) sh_mem[a[15:0]] = v;
   endfunction

   function automatic void wr32(logic [31:0] a, logic [31:0] v);
      logic [31:0] p;
      if (a >= rom_end_q || a >= rom_start_q) return;
      for (int k = 0; k < 4; k++) begin
         p = a + k;
         if (p < MEMSZ) sh_mem[p[15:0]] = 8'(v >> (24 - 8 * k));
      end
   endfunction

   function automatic logic [7:0] gr8(logic [7:0] i);
      return i < 8 ? sh_r8[i[2:0]] : 8'h00;
   endfunction

   function automatic logic [31:0] gr32(logic [7:0] i);
      return i < 8 ? sh_r32[i[2:0]] : 32'h0;
   endfunction

   function automatic void pr8(logic [7:0] i, logic [7:0] v);
      if (i < 8) sh_r8[i[2:0]] = v;
   endfunction

   function automatic void pr32(logic [7:0] i, logic [31:0] v);
      if (i < 8) sh_r32[i[2:0]] = v;
   endfunction

   function automatic void set_cmp(bit eq, bit gt, bit lt, bit ge, bit le);
      sh_flags = '{eq: eq, ne: !eq, gt: gt, lt: lt, ge: ge, le: le};
   endfunction

   function automatic void execute_instr();
      logic [7:0]  b [6];
      logic [31:0] pc, hi, lo, x, y, adv;
      bit          take, jump;
      pc = sh_pc;
      adv = 4;
      take = 0;
      jump = 0;
      if (pc >= video_start_q && pc + 1 < rom_start_q) pc = 0;
      if (pc > rom_end_q) pc = 0;
      for (int k = 0; k < 6; k++) b[k] = rd8(pc + k);
      hi = {b[1], b[2], b[3], b[4]};
      lo = {b[2], b[3], b[4], b[5]};
      case (b[0])
         OP_MOV8_IMM:  pr8(b[1], b[2]);
         OP_MOV32_IMM: begin pr32(b[1], lo); adv = 6; end
         OP_ST8_ABS:   begin wr8(hi, gr8(b[5])); adv = 6; end
         OP_ST32_ABS:  begin wr32(hi, gr32(b[5])); adv = 6; end
         OP_LD8_ABS:   begin pr8(b[1], rd8(lo)); adv = 6; end
         OP_LD32_ABS:  begin pr32(b[1], rd32(lo)); adv = 6; end
         OP_MOV8:      pr8(b[1], gr8(b[2]));
         OP_MOV32:     pr32(b[1], gr32(b[2]));
         OP_ST8_IND:   wr8(gr32(b[1]), gr32(b[2]));
         OP_LD8_IND:   pr8(b[1], rd8(gr32(b[2])));
         OP_ADD8:      pr8(b[1], gr8(b[2]) + gr8(b[3]));
         OP_SUB8:      pr8(b[1], gr8(b[2]) - gr8(b[3]));
         OP_DIV8:      pr8(b[1], gr8(b[3]) != 0 ? gr8(b[2]) / gr8(b[3]) : 8'h00);
         OP_MUL8:      pr8(b[1], gr8(b[2]) * gr8(b[3]));
         OP_ADD32:     pr32(b[1], gr32(b[2]) + gr32(b[3]));
         OP_SUB32:     pr32(b[1], gr32(b[2]) - gr32(b[3]));
         OP_DIV32:     pr32(b[1], gr32(b[3]) != 0 ? gr32(b[2]) / gr32(b[3]) : 32'h0);
         OP_MUL32:     pr32(b[1], gr32(b[2]) * gr32(b[3]));
         OP_JMP:       begin jump = 1; take = 1; end
         OP_JEQ:       begin jump = 1; take = sh_flags.eq; end
         OP_JNE:       begin jump = 1; take = sh_flags.ne; end
         OP_JLT:       begin jump = 1; take = sh_flags.lt; end
         OP_JGT:       begin jump = 1; take = sh_flags.gt; end
         OP_JLE:       begin jump = 1; take = sh_flags.le; end
         OP_JGE:       begin jump = 1; take = sh_flags.ge; end
         OP_AND8:      pr8(b[1], gr8(b[2]) & gr8(b[3]));
         OP_OR8:       pr8(b[1], gr8(b[2]) | gr8(b[3]));
         OP_NOT8:      pr8(b[1], ~gr8(b[2]));
         OP_XOR8:      pr8(b[1], gr8(b[2]) ^ gr8(b[3]));
         OP_CMP8: begin
            x = gr8(b[1]);
            y = gr8(b[2]);
            set_cmp(x == y, x > y, x < y, x >= y, x <= y);
         end
         OP_AND32:     pr32(b[1], gr32(b[2]) & gr32(b[3]));
         OP_OR32:      pr32(b[1], gr32(b[2]) | gr32(b[3]));
         OP_NOT32:     pr32(b[1], ~gr32(b[2]));
         OP_XOR32:     pr32(b[1], gr32(b[2]) ^ gr32(b[3]));
         OP_CMP32: begin
            // The 32-bit compare reports less as simply not greater.
            x = gr32(b[1]);
            y = gr32(b[2]);
            set_cmp(x == y, x > y, !(x > y), x >= y, !(x > y) || x == y);
         end
         OP_INC8:      pr8(b[1], gr8(b[2]) + 1);
         OP_DEC8:      pr8(b[1], gr8(b[2]) - 1);
         OP_SHL8:      pr8(b[1], gr8(b[3]) < 8 ? gr8(b[2]) << gr8(b[3]) : 8'h00);
         OP_SHR8:      pr8(b[1], gr8(b[3]) < 8 ? gr8(b[2]) >> gr8(b[3]) : 8'h00);
         OP_INC32:     pr32(b[1], gr32(b[2]) + 1);
         OP_DEC32:     pr32(b[1], gr32(b[2]) - 1);
         OP_SHL32:     pr32(b[1], gr32(b[3]) < 32 ? gr32(b[2]) << gr32(b[3]) : 32'h0);
         OP_SHR32:     pr32(b[1], gr32(b[3]) < 32 ? gr32(b[2]) >> gr32(b[3]) : 32'h0);
         OP_HLT:       begin sh_halt = 1; adv = 0; end
         OP_STB_IMM:   begin wr8(hi, b[5]); adv = 6; end
         default: ;
      endcase
      sh_pc = jump ? (take ? hi : pc + 6) : pc + adv;
   endfunction

   function automatic cpu_rsp_t predict_response(cpu_req_t r);
      cpu_rsp_t e;
      e.rdata = 8'h00;
      case (r.kind)
         REQ_LOAD: sh_mem[r.addr] = r.data;
         REQ_READ: e.rdata = rd8(r.addr);
         REQ_EXEC: if (!sh_halt) execute_instr();
         default: ;
      endcase
      e.pc = sh_pc;
      e.halted = sh_halt;
      e.flags = sh_flags;
      return e;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Driver.
   cpu_req_t cur_req;
   always @(negedge clock) begin
      bit beat_done;
      beat_done = req_taken;
      if (!reset) begin
         if (beat_done) begin
            req_taken = 1'b0;
            pending_reqs.pop_front();
            req_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         // A beat on offer stays until it is taken.
         if (!req_ch.valid || beat_done) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !source_pause) begin
               cur_req = pending_reqs[0];
               req_ch.valid <= 1'b1;
               req_ch.req_type <= cur_req.kind;
               req_ch.address <= cur_req.addr;
               req_ch.data <= cur_req.data;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) rsp_gap = 0;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: the predictor runs at request acceptance, so order follows the block.
   cpu_rsp_t got, want;
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            idle_cycles = 0;
            req_taken = 1'b1;
            expected_rsps.push_back(predict_response(
               '{kind: req_ch.req_type, addr: req_ch.address, data: req_ch.data}));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles = 0;
            rsp_taken = 1'b1;
            got = '{pc: rsp_ch.pc, halted: rsp_ch.halted,
                    flags: '{eq: rsp_ch.flag_equal, ne: rsp_ch.flag_not_equal,
                             gt: rsp_ch.flag_greater, lt: rsp_ch.flag_less,
                             ge: rsp_ch.flag_greater_eq, le: rsp_ch.flag_less_eq},
                    rdata: rsp_ch.read_data};
            if (expected_rsps.size() == 0) report("unexpected beat", 0, 0);
            else begin
               want = expected_rsps.pop_front();
               if (got.pc !== want.pc) report("pc", got.pc, want.pc);
               if (got.halted !== want.halted) report("halted", got.halted, want.halted);
               if (got.flags !== want.flags) report("flags", got.flags, want.flags);
               if (got.rdata !== want.rdata) report("read_data", got.rdata, want.rdata);
            end
         end
         if (idle_cycles >= IDLE_LIMIT + MEMSZ) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic push(logic [1:0] k, logic [15:0] a, logic [7:0] d);
      pending_reqs.push_back('{kind: k, addr: a, data: d});
   endtask

   task automatic place_instr(logic [15:0] a, logic [7:0] op, logic [7:0] o1, logic [7:0] o2,
                              logic [7:0] o3, logic [7:0] o4, logic [7:0] o5);
      push(REQ_LOAD, a, op);
      push(REQ_LOAD, a + 1, o1);
      push(REQ_LOAD, a + 2, o2);
      push(REQ_LOAD, a + 3, o3);
      push(REQ_LOAD, a + 4, o4);
      push(REQ_LOAD, a + 5, o5);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_ROM_START:   rom_start_q = v;
         CSR_ROM_END:     rom_end_q = v;
         CSR_VIDEO_START: video_start_q = v;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [7:0] rand_op();
      int s;
      s = $urandom_range(0, 19);
      if (s == 0) return $urandom_range(0, 255);
      if (s < 3) return $urandom_range(OP_JMP, OP_JGE);
      return $urandom_range(OP_MOV8_IMM, OP_STB_IMM - 0);
   endfunction

   // Random program of n instructions at base, then steps requests, mostly single steps.
   task automatic random_program(logic [15:0] base, int n, int steps);
      logic [7:0] op, o1, o2, o3, o4, o5;
      for (int i = 0; i < n; i++) begin
         op = rand_op();
         if (op == OP_HLT && $urandom_range(0, 7) != 0) op = OP_INC32;
         o1 = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
         o2 = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
         o3 = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
         o4 = $urandom_range(0, 255);
         o5 = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8);
         // Keep jump targets mostly inside the program and store addresses mostly outside it.
         if (op inside {[OP_JMP:OP_JGE], OP_ST8_ABS, OP_ST32_ABS, OP_STB_IMM}
             && $urandom_range(0, 3) != 0) begin
            o1 = 0; o2 = 0;
            {o3, o4} = base + 6 * $urandom_range(0, n - 1);
            if (op inside {OP_ST8_ABS, OP_ST32_ABS, OP_STB_IMM})
               {o3, o4} = $urandom_range(0, 3) == 0 ? 16'hffff - $urandom_range(0, 4)
                                                   : base + 6 * n + $urandom_range(0, 40);
         end
         if (op inside {OP_LD8_ABS, OP_LD32_ABS} && $urandom_range(0, 1) == 1) begin
            o2 = 0; {o3, o4, o5} = {8'h00, base + $urandom_range(0, 6 * n)};
         end
         place_instr(base + 6 * i, op, o1, o2, o3, o4, o5);
      end
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(0, 9) == 0) push(REQ_READ, $urandom_range(0, 65535), 0);
         else if ($urandom_range(0, 29) == 0) push(REQ_NOP, $urandom, $urandom);
         else push(REQ_EXEC, $urandom, $urandom);
      end
   endtask

   initial begin
      int base;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_LOAD;
      req_ch.address = '0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_ROM_START;
      csr_ch.wdata = '0;
      rsp_ch.ready = 1'b0;
      foreach (sh_mem[i]) sh_mem[i] = 8'h00;
      foreach (sh_r8[i]) begin sh_r8[i] = 0; sh_r32[i] = 0; end
      rom_start_q = ROM_START_RST;
      rom_end_q = ROM_END_RST;
      video_start_q = VIDEO_START_RST;
      sh_pc = ROM_START_RST;
      sh_flags = '0;
      sh_halt = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed boot program at the reset PC.
      place_instr(16'hF000, OP_MOV32_IMM, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      place_instr(16'hF006, OP_MOV32_IMM, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
      place_instr(16'hF00C, OP_DIV32, 8'd3, 8'd1, 8'd2, 0, 0);
      place_instr(16'hF010, OP_MOV8_IMM, 8'd4, 8'd9, 0, 0, 0);
      place_instr(16'hF014, OP_SHL8, 8'd5, 8'd4, 8'd4, 0, 0);
      place_instr(16'hF018, OP_CMP32, 8'd1, 8'd1, 0, 0, 0);
      place_instr(16'hF01C, OP_JLT, 8'h00, 8'h00, 8'hF0, 8'h24, 0);
      place_instr(16'hF024, OP_CMP8, 8'd4, 8'd9, 0, 0, 0);
      place_instr(16'hF028, OP_ST32_ABS, 8'h00, 8'h00, 8'hEF, 8'hFE, 8'd1);
      place_instr(16'hF02E, OP_STB_IMM, 8'h00, 8'h00, 8'h00, 8'h10, 8'hA5);
      place_instr(16'hF034, OP_JMP, 8'h00, 8'h00, 8'hF0, 8'h3A, 0);
      place_instr(16'hF03A, OP_HLT, 0, 0, 0, 0, 0);
      push(REQ_LOAD, 16'hFFFF, 8'hFF);
      push(REQ_READ, 16'hFFFF, 0);
      for (int i = 0; i < 14; i++) push(REQ_EXEC, 16'hFFFF, 8'hFF);
      push(REQ_READ, 16'hEFFE, 0);
      push(REQ_READ, 16'h0010, 0);
      // The receiver stalls while the sender keeps offering, once the memory
      // clear is over and beats can flow.
      while (!req_ch.ready) @(posedge clock);
      hold_off = 300;
      wait_drained();

      // Phases under several register settings; a halted core needs a reset, so
      // each phase avoids the halt opcode except rarely.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_csr(CSR_ROM_START, 17'h10000); write_csr(CSR_ROM_END, 17'h10000);
                     write_csr(CSR_VIDEO_START, 17'h10000); end
            1: begin write_csr(CSR_ROM_START, 17'd0); write_csr(CSR_VIDEO_START, 17'd0); end
            2: begin write_csr(CSR_ROM_START, 17'h8000); write_csr(CSR_ROM_END, 17'h9000);
                     write_csr(CSR_VIDEO_START, 17'h4000); end
            3: write_csr(CSR_ROM_END, 17'd0);
            4: begin write_csr(CSR_ROM_START, 17'hF000); write_csr(CSR_ROM_END, 17'h10000);
                     write_csr(CSR_VIDEO_START, 17'h8000); end
            default: begin
               write_csr(CSR_ROM_START, $urandom_range(0, 65536));
               write_csr(CSR_ROM_END, $urandom_range(1024, 65536));
               write_csr(CSR_VIDEO_START, $urandom_range(0, 65536));
            end
         endcase
         base = sh_pc < 65536 - 200 ? sh_pc : 0;
         random_program(base, 12, 12);
         random_program(0, 10, 10);
         wait_drained();
      end
      // Pause the sender until the core has answered everything outstanding.
      source_pause = 1'b1;
      wait_drained();
      source_pause = 1'b0;
      for (int i = 0; i < 40; i++)
         push($urandom_range(0, 3), $urandom, $urandom);
      wait_drained();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// File: files.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_if.sv
hw/rtl/bcc_mem.sv
hw/rtl/bcc_div.sv
hw/rtl/byte_coded_cpu_step.sv
hw/rtl/bcc_checker.sv
tb/byte_coded_cpu_step_tb.sv
